### src/stip_pkg.sv
// ----------------------------------------------------------------------------
// String-to-integer parser package
// Shared types, constants and character helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package stip_pkg;

  localparam int unsigned CHAR_W            = 8;
  localparam int unsigned RADIX_W           = 6;
  localparam int unsigned VALUE_BITS_DEF    = 32;
  localparam int unsigned POSITION_BITS_DEF = 12;

  localparam logic [RADIX_W-1:0] RADIX_RESET  = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN    = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX    = 6'd36;
  localparam logic [RADIX_W-1:0] BASE_AUTO    = 6'd0;
  localparam logic [RADIX_W-1:0] BASE_INVALID = 6'd1;
  localparam logic [RADIX_W-1:0] BASE_OCT     = 6'd8;
  localparam logic [RADIX_W-1:0] BASE_DEC     = 6'd10;
  localparam logic [RADIX_W-1:0] BASE_HEX     = 6'd16;
  localparam logic [RADIX_W-1:0] DIGIT_NONE   = 6'd36;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
  localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
  localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_NINE  = 8'h39;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_UX    = 8'h58;
  localparam logic [CHAR_W-1:0] CH_UZ    = 8'h5A;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;
  localparam logic [CHAR_W-1:0] CH_LX    = 8'h78;
  localparam logic [CHAR_W-1:0] CH_LZ    = 8'h7A;
  localparam logic [CHAR_W-1:0] ALPHA_OFS = 8'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_LEAD,
    PH_SIGNED,
    PH_ZERO,
    PH_HEX,
    PH_DIGITS
  } phase_e;

  typedef struct packed {
    phase_e             phase;
    logic               negative;
    logic [RADIX_W-1:0] base;
    logic               overflow;
    logic               digit_seen;
  } ctrl_t;

  function automatic logic is_space(input logic [CHAR_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic [RADIX_W-1:0] digit_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] v;
    v = CHAR_W'(DIGIT_NONE);
    if ((c >= CH_ZERO) && (c <= CH_NINE)) begin
      v = c - CH_ZERO;
    end else if ((c >= CH_UA) && (c <= CH_UZ)) begin
      v = c - CH_UA + ALPHA_OFS;
    end else if ((c >= CH_LA) && (c <= CH_LZ)) begin
      v = c - CH_LA + ALPHA_OFS;
    end
    return v[RADIX_W-1:0];
  endfunction

endpackage : stip_pkg

`default_nettype wire

### src/stip_if.sv
// ----------------------------------------------------------------------------
// String-to-integer parser channels
// Valid/ready channels for characters, results and the radix register.
// ----------------------------------------------------------------------------
`default_nettype none

interface stip_in_if;
  import stip_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              start_of_string;

  modport source (output valid, character, start_of_string, input ready);
  modport sink   (input valid, character, start_of_string, output ready);
endinterface : stip_in_if

interface stip_out_if #(
  parameter int unsigned VALUE_BITS    = stip_pkg::VALUE_BITS_DEF,
  parameter int unsigned POSITION_BITS = stip_pkg::POSITION_BITS_DEF
);
  logic                           valid;
  logic                           ready;
  logic signed [VALUE_BITS-1:0]   parsed_value;
  logic        [POSITION_BITS-1:0] end_offset;
  logic                           overflowed;
  logic                           had_digits;

  modport source (output valid, parsed_value, end_offset, overflowed, had_digits,
                  input ready);
  modport sink   (input valid, parsed_value, end_offset, overflowed, had_digits,
                  output ready);
endinterface : stip_out_if

interface stip_cfg_if;
  import stip_pkg::*;
  logic               valid;
  logic               ready;
  logic [RADIX_W-1:0] radix;

  modport source (output valid, radix, input ready);
  modport sink   (input valid, radix, output ready);
endinterface : stip_cfg_if

`default_nettype wire

### src/stip_step.sv
// ----------------------------------------------------------------------------
// String-to-integer parser step
// Next-state and result logic for one character.
// ----------------------------------------------------------------------------
`default_nettype none

module stip_step #(
  parameter int unsigned VALUE_BITS    = stip_pkg::VALUE_BITS_DEF,
  parameter int unsigned POSITION_BITS = stip_pkg::POSITION_BITS_DEF
) (
  input  logic [stip_pkg::CHAR_W-1:0]  char_i,
  input  logic                         start_i,
  input  logic [stip_pkg::RADIX_W-1:0] radix_i,
  input  stip_pkg::ctrl_t              ctrl_i,
  input  logic [VALUE_BITS-1:0]        acc_i,
  input  logic [POSITION_BITS-1:0]     pos_i,
  output stip_pkg::ctrl_t              ctrl_o,
  output logic [VALUE_BITS-1:0]        acc_o,
  output logic [POSITION_BITS-1:0]     pos_o,
  output logic                         emit_o,
  output logic signed [VALUE_BITS-1:0] value_o,
  output logic [POSITION_BITS-1:0]     offset_o,
  output logic                         overflowed_o,
  output logic                         had_digits_o
);
  import stip_pkg::*;

  localparam int unsigned PW = VALUE_BITS + RADIX_W;
  localparam logic [VALUE_BITS-1:0]    HALF    = VALUE_BITS'(1) << (VALUE_BITS - 1);
  localparam logic [POSITION_BITS-1:0] POS_MAX = '1;

  function automatic logic [POSITION_BITS-1:0] pos_add(input logic [POSITION_BITS-1:0] p,
                                                        input logic [1:0] k);
    logic [POSITION_BITS:0] s;
    s = {1'b0, p} + (POSITION_BITS+1)'(k);
    return (s > {1'b0, POS_MAX}) ? POS_MAX : s[POSITION_BITS-1:0];
  endfunction

  ctrl_t                  st;
  logic [VALUE_BITS-1:0]  acc;
  logic [POSITION_BITS-1:0] pos;
  logic                   busy;
  logic                   dig_step;
  logic                   from_hex;
  logic [RADIX_W-1:0]     d;
  logic                   d_ok;
  logic [PW-1:0]          prod;
  logic [PW-1:0]          lim;
  logic                   emit;

  always_comb begin
    st       = ctrl_i;
    acc      = acc_i;
    pos      = pos_i;
    busy     = 1'b1;
    dig_step = 1'b0;
    from_hex = 1'b0;
    emit     = 1'b0;
    d        = digit_of(char_i);
    d_ok     = 1'b0;
    prod     = '0;
    lim      = '0;

    if (start_i) begin
      st.phase      = PH_LEAD;
      st.negative   = 1'b0;
      st.overflow   = 1'b0;
      st.digit_seen = 1'b0;
      acc           = '0;
      pos           = '0;
      if ((radix_i == BASE_AUTO) || ((radix_i >= RADIX_MIN) && (radix_i <= RADIX_MAX))) begin
        st.base = radix_i;
      end else begin
        st.base = BASE_INVALID;
      end
    end else if (ctrl_i.phase == PH_IDLE) begin
      busy = 1'b0;
    end

    if (busy && (st.phase == PH_LEAD)) begin
      if (is_space(char_i)) begin
        pos  = pos_add(pos, 2'd1);
        busy = 1'b0;
      end else if ((char_i == CH_MINUS) || (char_i == CH_PLUS)) begin
        st.negative = (char_i == CH_MINUS);
        st.phase    = PH_SIGNED;
        pos         = pos_add(pos, 2'd1);
        busy        = 1'b0;
      end else begin
        st.phase = PH_SIGNED;
      end
    end

    if (busy && (st.phase == PH_SIGNED)) begin
      if ((char_i == CH_ZERO) && ((st.base == BASE_AUTO) || (st.base == BASE_HEX))) begin
        st.digit_seen = 1'b1;
        st.phase      = PH_ZERO;
        pos           = pos_add(pos, 2'd1);
        busy          = 1'b0;
      end else begin
        if (st.base == BASE_AUTO) begin
          st.base = BASE_DEC;
        end
        st.phase = PH_DIGITS;
      end
    end else if (busy && (st.phase == PH_ZERO)) begin
      if ((char_i == CH_LX) || (char_i == CH_UX)) begin
        st.base  = BASE_HEX;
        st.phase = PH_HEX;
        busy     = 1'b0;
      end else begin
        if (st.base == BASE_AUTO) begin
          st.base = BASE_OCT;
        end
        st.phase = PH_DIGITS;
      end
    end else if (busy && (st.phase == PH_HEX)) begin
      from_hex = 1'b1;
    end

    dig_step = busy;

    if (dig_step) begin
      d_ok = (st.base >= RADIX_MIN) && (d < st.base);
      if (!d_ok) begin
        emit     = 1'b1;
        st.phase = PH_IDLE;
      end else begin
        prod = PW'(acc) * PW'(st.base) + PW'(d);
        lim  = PW'(st.negative ? HALF : HALF - VALUE_BITS'(1));
        if (st.overflow || (prod > lim)) begin
          st.overflow = 1'b1;
        end else begin
          acc = prod[VALUE_BITS-1:0];
        end
        st.digit_seen = 1'b1;
        st.phase      = PH_DIGITS;
        pos           = pos_add(pos, from_hex ? 2'd2 : 2'd1);
      end
    end
  end

  assign ctrl_o = st;
  assign acc_o  = acc;
  assign pos_o  = pos;
  assign emit_o = emit;

  always_comb begin
    if (st.overflow) begin
      value_o = st.negative ? HALF : HALF - VALUE_BITS'(1);
    end else if (st.negative) begin
      value_o = VALUE_BITS'(0) - acc;
    end else begin
      value_o = acc;
    end
  end

  assign offset_o     = st.digit_seen ? pos : '0;
  assign overflowed_o = st.overflow;
  assign had_digits_o = st.digit_seen;

endmodule : stip_step

`default_nettype wire

### src/string_to_integer_parser.sv
// ----------------------------------------------------------------------------
// String-to-integer parser
// Signed integer parse of a byte stream with a selectable radix.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one character per item; start_of_string marks the first
//         byte of a new string and restarts any parse in progress.
//   out_o carries one result per string, on the first byte not accepted
//         as part of the number (NUL included).
//   cfg_i writes the radix (0 = automatic, 2..36); it is always ready and
//         is latched by the parse when a string starts.
// Timing:
//   A character is registered in the input register on acceptance and
//   processed once the result register is free; its result is registered
//   in the result register and shown on out_o from there.
//   One character per cycle is sustained while out_o is not stalled; the
//   parse state loop (compare, multiply by the radix, add) is combinational.
// Reset:
//   Radix returns to 10, the parser is idle and no result is pending.
// Stall:
//   The result register holds while out_o.ready is low; one more
//   character is taken into the input register, then in_i.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module string_to_integer_parser #(
  parameter int unsigned VALUE_BITS    = stip_pkg::VALUE_BITS_DEF,
  parameter int unsigned POSITION_BITS = stip_pkg::POSITION_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  stip_in_if.sink      in_i,
  stip_out_if.source   out_o,
  stip_cfg_if.sink     cfg_i
);
  import stip_pkg::*;

  localparam logic [VALUE_BITS-1:0] HALF = VALUE_BITS'(1) << (VALUE_BITS - 1);

  logic [RADIX_W-1:0]       radix_q;
  logic                     in_valid_q;
  logic [CHAR_W-1:0]        char_q;
  logic                     start_q;
  ctrl_t                    ctrl_q, ctrl_d;
  logic [VALUE_BITS-1:0]    acc_q, acc_d;
  logic [POSITION_BITS-1:0] pos_q, pos_d;
  logic                     res_valid_q;
  logic signed [VALUE_BITS-1:0] value_q, value_d;
  logic [POSITION_BITS-1:0] offset_q, offset_d;
  logic                     ovf_q, ovf_d;
  logic                     had_q, had_d;
  logic                     emit;
  logic                     res_free;
  logic                     step_fire;

  assign res_free  = !res_valid_q || out_o.ready;
  assign step_fire = in_valid_q && res_free;
  assign in_i.ready  = !in_valid_q || res_free;
  assign cfg_i.ready = 1'b1;

  stip_step #(
    .VALUE_BITS    (VALUE_BITS),
    .POSITION_BITS (POSITION_BITS)
  ) u_step (
    .char_i       (char_q),
    .start_i      (start_q),
    .radix_i      (radix_q),
    .ctrl_i       (ctrl_q),
    .acc_i        (acc_q),
    .pos_i        (pos_q),
    .ctrl_o       (ctrl_d),
    .acc_o        (acc_d),
    .pos_o        (pos_d),
    .emit_o       (emit),
    .value_o      (value_d),
    .offset_o     (offset_d),
    .overflowed_o (ovf_d),
    .had_digits_o (had_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radix_q <= RADIX_RESET;
    end else if (cfg_i.valid) begin
      radix_q <= cfg_i.radix;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      char_q  <= in_i.character;
      start_q <= in_i.start_of_string;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctrl_q <= '{phase: PH_IDLE, negative: 1'b0, base: '0, overflow: 1'b0,
                  digit_seen: 1'b0};
      acc_q  <= '0;
      pos_q  <= '0;
    end else if (step_fire) begin
      ctrl_q <= ctrl_d;
      acc_q  <= acc_d;
      pos_q  <= pos_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (step_fire && emit) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_fire && emit) begin
      value_q  <= value_d;
      offset_q <= offset_d;
      ovf_q    <= ovf_d;
      had_q    <= had_d;
    end
  end

  assign out_o.valid        = res_valid_q;
  assign out_o.parsed_value = value_q;
  assign out_o.end_offset   = offset_q;
  assign out_o.overflowed   = ovf_q;
  assign out_o.had_digits   = had_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !$past(res_valid_q) |-> $past(step_fire))
    else $error("result raised without a processed item");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_q <= HALF)
    else $error("accumulator beyond signed limit");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.had_digits |->
      (out_o.end_offset == '0) && (out_o.parsed_value == '0) && !out_o.overflowed)
    else $error("digitless result not zero");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |=> out_o.valid)
    else $error("pending result dropped");

endmodule : string_to_integer_parser

`default_nettype wire
